// ===== sv/assert_macros.svh =====
// Assertion helper macros for the RTL of the range-delete filter.
// Empty bodies for synthesis; checks use clk_i and rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/lrdf_pkg.sv =====
// Package for the leveled range-delete filter: word types, request codes,
// sequencer states and default sizes. No dependencies.
package lrdf_pkg;

  localparam int NumLevelsDef = 8;
  localparam int MaxRangesDef = 64;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_PUNCH  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         level;
    logic signed [63:0] range_low;
    logic signed [63:0] range_high;
    logic signed [63:0] probe_key;
  } lrdf_req_t;

  typedef struct packed {
    logic       alive;
    logic       overflow;
    logic [6:0] level_count;
  } lrdf_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WR0,
    ST_WR1,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_RESP
  } state_e;

endpackage

// ===== sv/lrdf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lrdf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/leveled_range_delete_filter.sv =====
// Channel  Signals                          Word
// in       in_valid_i / in_stall_o          in_data_i  (lrdf_req_t)
// out      out_valid_o / out_stall_i        out_data_o (lrdf_rsp_t)
//
// Each word scans stored ranges, then may move ranges for a shift or
// compaction and do up to 2 writes, all through the single range RAM port
// pair (one read, one write per cycle); in_stall_o holds off the next word.
// Reset clears the per-level counts and control; range RAM is not cleared.
// A result waiting on out_stall_i does not block acceptance of the next word.
// Depends on lrdf_pkg, lrdf_ram and assert_macros.svh.
`include "assert_macros.svh"

module leveled_range_delete_filter import lrdf_pkg::*; #(
  parameter int NUM_LEVELS = NumLevelsDef,
  parameter int MAX_RANGES = MaxRangesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lrdf_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lrdf_rsp_t out_data_o
);

  localparam int LVW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CW  = $clog2(MAX_RANGES + 1);
  localparam int AW  = $clog2(NUM_LEVELS * MAX_RANGES);
  localparam logic [CW-1:0] CntMax = CW'(MAX_RANGES);

  state_e state_q, state_d;

  logic [1:0]         op_q, op_d;
  logic [LVW-1:0]     lv_q, lv_d;
  logic               inr_q, inr_d;
  logic signed [63:0] lo_q, lo_d, hi_q, hi_d, key_q, key_d;
  logic [CW-1:0]      p_q, p_d, i_q, i_d, j_q, j_d;
  logic               found_q, found_d;
  logic signed [63:0] nlo_q, nlo_d, nhi_q, nhi_d, s_q, s_d, e_q, e_d;
  logic               alive_q, alive_d, ovf_q, ovf_d;
  logic [CW-1:0]      ncnt_q, ncnt_d, src_q, src_d, stop_q, stop_d, gap_q, gap_d;
  logic               wr2_q, wr2_d, comp_q, comp_d;
  logic [CW-1:0]      w0i_q, w0i_d, w1i_q, w1i_d;
  logic [127:0]       w0_q, w0_d, w1_q, w1_d;
  logic               out_valid_q, out_valid_d;
  lrdf_rsp_t          out_q, out_d;

  logic [CW-1:0] cnt_q [NUM_LEVELS];
  logic          cnt_we;
  logic [CW-1:0] cur_cnt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [127:0]  ram_wdata, ram_rdata;
  logic signed [63:0] rd_s, rd_e, kp1;

  assign cur_cnt = cnt_q[lv_q];
  assign rd_s    = ram_rdata[127:64];
  assign rd_e    = ram_rdata[63:0];
  assign kp1     = key_q + 64'sd1;

  function automatic logic [AW-1:0] addr_of(input logic [LVW-1:0] lv,
                                            input logic [CW-1:0] idx);
    return AW'(int'(lv) * MAX_RANGES + int'(idx));
  endfunction

  lrdf_ram #(
    .Width(128),
    .Depth(NUM_LEVELS * MAX_RANGES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Reads and writes of the RAM never fall in the same state, so a copy step
  // always reads data already written back: no forwarding is needed.
  always_comb begin
    state_d = state_q;
    op_d = op_q; lv_d = lv_q; inr_d = inr_q;
    lo_d = lo_q; hi_d = hi_q; key_d = key_q;
    p_d = p_q; i_d = i_q; j_d = j_q; found_d = found_q;
    nlo_d = nlo_q; nhi_d = nhi_q; s_d = s_q; e_d = e_q;
    alive_d = alive_q; ovf_d = ovf_q; ncnt_d = ncnt_q;
    src_d = src_q; stop_d = stop_q; gap_d = gap_q;
    wr2_d = wr2_q; comp_d = comp_q;
    w0i_d = w0i_q; w1i_d = w1i_q; w0_d = w0_q; w1_d = w1_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    cnt_we = 1'b0;
    ram_we = 1'b0;
    ram_waddr = addr_of(lv_q, w0i_q);
    ram_wdata = w0_q;
    ram_raddr = addr_of(lv_q, src_q);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i.req_type;
          lv_d = LVW'(in_data_i.level);
          inr_d = (int'(in_data_i.level) < NUM_LEVELS);
          lo_d = in_data_i.range_low;
          hi_d = in_data_i.range_high;
          key_d = in_data_i.probe_key;
          nlo_d = in_data_i.range_low;
          nhi_d = in_data_i.range_high;
          p_d = '0; i_d = '0; j_d = '0; found_d = 1'b0;
          alive_d = 1'b0; ovf_d = 1'b0;
          wr2_d = 1'b0; comp_d = 1'b0;
          if (int'(in_data_i.level) >= NUM_LEVELS) begin
            alive_d = (in_data_i.req_type == REQ_QUERY);
            ncnt_d = '0;
            state_d = ST_RESP;
          end else begin
            ncnt_d = cnt_q[LVW'(in_data_i.level)];
            if ((in_data_i.req_type == REQ_INSERT &&
                 in_data_i.range_low < in_data_i.range_high) ||
                in_data_i.req_type == REQ_QUERY ||
                in_data_i.req_type == REQ_PUNCH) begin
              state_d = (cnt_q[LVW'(in_data_i.level)] == '0) ? ST_DECIDE : ST_SCAN_RD;
            end else begin
              state_d = ST_RESP;
            end
          end
        end
      end

      ST_SCAN_RD: begin
        ram_raddr = addr_of(lv_q, p_q);
        state_d = ST_SCAN_EV;
      end

      ST_SCAN_EV: begin
        state_d = (p_q + 1'b1 == cur_cnt) ? ST_DECIDE : ST_SCAN_RD;
        p_d = p_q + 1'b1;
        if (op_q == REQ_INSERT) begin
          if (!found_q && rd_e < lo_q) begin
            i_d = p_q + 1'b1;
            j_d = p_q + 1'b1;
          end else if (rd_s <= hi_q) begin
            if (!found_q) begin
              i_d = p_q;
            end
            found_d = 1'b1;
            if (rd_s < nlo_q) nlo_d = rd_s;
            if (rd_e > nhi_q) nhi_d = rd_e;
            j_d = p_q + 1'b1;
          end else begin
            if (!found_q) begin
              i_d = p_q;
              j_d = p_q;
            end
            state_d = ST_DECIDE;
          end
        end else if (key_q >= rd_s && key_q < rd_e) begin
          found_d = 1'b1;
          i_d = p_q;
          s_d = rd_s;
          e_d = rd_e;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_d = ST_RESP;
        ncnt_d = cur_cnt;
        case (op_q)
          REQ_QUERY: alive_d = !found_q;
          REQ_INSERT: begin
            if (j_q == i_q) begin
              if (cur_cnt >= CntMax) begin
                ovf_d = 1'b1;
              end else begin
                w0i_d = i_q;
                w0_d = {lo_q, hi_q};
                ncnt_d = cur_cnt + 1'b1;
                src_d = cur_cnt - 1'b1;
                stop_d = i_q;
                state_d = (cur_cnt > i_q) ? ST_SHIFT_RD : ST_WR0;
              end
            end else begin
              w0i_d = i_q;
              w0_d = {nlo_q, nhi_q};
              gap_d = j_q - i_q - 1'b1;
              src_d = j_q;
              comp_d = (j_q - i_q != CW'(1)) && (j_q < cur_cnt);
              ncnt_d = cur_cnt - (j_q - i_q - 1'b1);
              state_d = ST_WR0;
            end
          end
          REQ_PUNCH: begin
            if (found_q) begin
              if (s_q == key_q && kp1 >= e_q) begin
                gap_d = CW'(1);
                src_d = i_q + 1'b1;
                ncnt_d = cur_cnt - 1'b1;
                if (i_q + 1'b1 < cur_cnt) begin
                  comp_d = 1'b1;
                  state_d = ST_COMP_RD;
                end
              end else if (s_q == key_q) begin
                w0i_d = i_q;
                w0_d = {kp1, e_q};
                state_d = ST_WR0;
              end else if (kp1 >= e_q) begin
                w0i_d = i_q;
                w0_d = {s_q, key_q};
                state_d = ST_WR0;
              end else if (cur_cnt >= CntMax) begin
                ovf_d = 1'b1;
              end else begin
                // split: old range keeps [s, key), new one [key+1, e) follows it
                w0i_d = i_q;
                w0_d = {s_q, key_q};
                w1i_d = i_q + 1'b1;
                w1_d = {kp1, e_q};
                wr2_d = 1'b1;
                ncnt_d = cur_cnt + 1'b1;
                src_d = cur_cnt - 1'b1;
                stop_d = i_q + 1'b1;
                state_d = (cur_cnt > i_q + 1'b1) ? ST_SHIFT_RD : ST_WR0;
              end
            end
          end
          default: ;
        endcase
      end

      ST_SHIFT_RD: begin
        ram_raddr = addr_of(lv_q, src_q);
        state_d = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        ram_we = 1'b1;
        ram_waddr = addr_of(lv_q, src_q + 1'b1);
        ram_wdata = ram_rdata;
        if (src_q == stop_q) begin
          state_d = ST_WR0;
        end else begin
          src_d = src_q - 1'b1;
          state_d = ST_SHIFT_RD;
        end
      end

      ST_WR0: begin
        ram_we = 1'b1;
        state_d = wr2_q ? ST_WR1 : (comp_q ? ST_COMP_RD : ST_RESP);
      end

      ST_WR1: begin
        ram_we = 1'b1;
        ram_waddr = addr_of(lv_q, w1i_q);
        ram_wdata = w1_q;
        state_d = comp_q ? ST_COMP_RD : ST_RESP;
      end

      ST_COMP_RD: begin
        ram_raddr = addr_of(lv_q, src_q);
        state_d = ST_COMP_WR;
      end

      ST_COMP_WR: begin
        ram_we = 1'b1;
        ram_waddr = addr_of(lv_q, src_q - gap_q);
        ram_wdata = ram_rdata;
        if (src_q + 1'b1 == cur_cnt) begin
          state_d = ST_RESP;
        end else begin
          src_d = src_q + 1'b1;
          state_d = ST_COMP_RD;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.alive = alive_q;
          out_d.overflow = ovf_q;
          out_d.level_count = 7'(ncnt_q);
          cnt_we = inr_q;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int n = 0; n < NUM_LEVELS; n++) begin
        cnt_q[n] <= '0;
      end
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (cnt_we) begin
        cnt_q[lv_q] <= ncnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; lv_q <= lv_d; inr_q <= inr_d;
    lo_q <= lo_d; hi_q <= hi_d; key_q <= key_d;
    p_q <= p_d; i_q <= i_d; j_q <= j_d; found_q <= found_d;
    nlo_q <= nlo_d; nhi_q <= nhi_d; s_q <= s_d; e_q <= e_d;
    alive_q <= alive_d; ovf_q <= ovf_d; ncnt_q <= ncnt_d;
    src_q <= src_d; stop_q <= stop_d; gap_q <= gap_d;
    wr2_q <= wr2_d; comp_q <= comp_d;
    w0i_q <= w0i_d; w1i_q <= w1i_d; w0_q <= w0_d; w1_q <= w1_d;
    out_q <= out_d;
  end

  `ASSERT_NEVER(a_cnt_max, state_q == ST_RESP && ncnt_q > CntMax, "count above capacity")
  `ASSERT_CHK(a_scan_bound, state_q == ST_SCAN_RD |-> p_q < cur_cnt, "scan past level count")
  `ASSERT_CHK(a_ovf_full, state_q == ST_RESP && ovf_q |-> cur_cnt == CntMax,
              "overflow on a level that is not full")
  `ASSERT_CHK(a_alive_query, state_q == ST_RESP && alive_q |-> op_q == REQ_QUERY,
              "alive set for a non-query word")
  `ASSERT_CHK(a_idle_resp, $rose(out_valid_o) |-> $past(state_q) == ST_RESP,
              "result word raised outside response state")

endmodule

// ===== verif/tb_leveled_range_delete_filter.sv =====
// Testbench for leveled_range_delete_filter: directed and random request words
// checked against a behavioral range-list model per level. Depends on lrdf_pkg.
`timescale 1ns / 1ps

module tb_leveled_range_delete_filter import lrdf_pkg::*;;

  localparam int NLEV = 8;
  localparam int MAXR = 64;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  lrdf_req_t in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  lrdf_rsp_t out_data_o;

  leveled_range_delete_filter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow range lists
  logic signed [63:0] lo_tab [NLEV][MAXR];
  logic signed [63:0] hi_tab [NLEV][MAXR];
  int                 cnt_tab [NLEV];

  lrdf_rsp_t rsp_pending [$];
  int        n_err;
  int        n_words;
  int        n_rsp;
  int        n_ovf;
  int        n_dead;

  function automatic void shift_up_at(int lv, int from, int cnt);
    for (int k = cnt; k > from; k--) begin
      lo_tab[lv][k] = lo_tab[lv][k-1];
      hi_tab[lv][k] = hi_tab[lv][k-1];
    end
  endfunction

  function automatic void remove_span(int lv, int at, int gone, int cnt);
    for (int k = at + gone; k < cnt; k++) begin
      lo_tab[lv][k-gone] = lo_tab[lv][k];
      hi_tab[lv][k-gone] = hi_tab[lv][k];
    end
  endfunction

  function automatic lrdf_rsp_t apply_request(lrdf_req_t rq);
    lrdf_rsp_t          r;
    int                 lv;
    int                 cnt;
    int                 i;
    int                 j;
    logic signed [63:0] nlo;
    logic signed [63:0] nhi;
    logic signed [63:0] s;
    logic signed [63:0] e;
    logic signed [63:0] key;
    r   = '0;
    lv  = rq.level;
    cnt = cnt_tab[lv];
    key = rq.probe_key;
    case (rq.req_type)
      REQ_INSERT: begin
        if (rq.range_low < rq.range_high) begin
          i = 0;
          while (i < cnt && hi_tab[lv][i] < rq.range_low) i++;
          j   = i;
          nlo = rq.range_low;
          nhi = rq.range_high;
          while (j < cnt && lo_tab[lv][j] <= rq.range_high) begin
            if (lo_tab[lv][j] < nlo) nlo = lo_tab[lv][j];
            if (hi_tab[lv][j] > nhi) nhi = hi_tab[lv][j];
            j++;
          end
          if (j == i) begin
            if (cnt >= MAXR) begin
              r.overflow = 1'b1;
            end else begin
              shift_up_at(lv, i, cnt);
              lo_tab[lv][i] = rq.range_low;
              hi_tab[lv][i] = rq.range_high;
              cnt++;
            end
          end else begin
            lo_tab[lv][i] = nlo;
            hi_tab[lv][i] = nhi;
            remove_span(lv, i + 1, j - i - 1, cnt);
            cnt = cnt - (j - i - 1);
          end
        end
      end
      REQ_QUERY: begin
        r.alive = 1'b1;
        for (i = 0; i < cnt; i++)
          if (key >= lo_tab[lv][i] && key < hi_tab[lv][i]) r.alive = 1'b0;
      end
      REQ_PUNCH: begin
        for (i = 0; i < cnt; i++)
          if (key >= lo_tab[lv][i] && key < hi_tab[lv][i]) break;
        if (i < cnt) begin
          s = lo_tab[lv][i];
          e = hi_tab[lv][i];
          if (s == key) begin
            if (key + 64'sd1 >= e) begin
              remove_span(lv, i, 1, cnt);
              cnt--;
            end else begin
              lo_tab[lv][i] = key + 64'sd1;
            end
          end else if (key + 64'sd1 >= e) begin
            hi_tab[lv][i] = key;
          end else if (cnt >= MAXR) begin
            r.overflow = 1'b1;
          end else begin
            shift_up_at(lv, i + 1, cnt);
            hi_tab[lv][i]   = key;
            lo_tab[lv][i+1] = key + 64'sd1;
            hi_tab[lv][i+1] = e;
            cnt++;
          end
        end
      end
      default: ;
    endcase
    cnt_tab[lv]   = cnt;
    r.level_count = 7'(cnt);
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  int  idle_sender;
  int  idle_receiver;
  initial begin
    idle_sender   = 1;
    idle_receiver = 1;
  end

  // valid stays up after acceptance so back-to-back words need one drive per edge;
  // it drops when a gap follows or when the sender waits for results
  task automatic send_word(lrdf_req_t rq);
    int g;
    lrdf_rsp_t exp_rsp;
    g = idle_sender ? gap_len() : 0;
    if (g != 0) in_valid_i <= 1'b0;
    repeat (g) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_rsp = apply_request(rq);
    rsp_pending = {rsp_pending, exp_rsp};
    n_words++;
    if (rq.req_type == REQ_QUERY && !exp_rsp.alive) n_dead++;
    if (exp_rsp.overflow) n_ovf++;
  endtask

  function automatic lrdf_req_t mk(logic [1:0] t, logic [2:0] lv, logic signed [63:0] lo,
                                   logic signed [63:0] hi, logic signed [63:0] key);
    lrdf_req_t rq;
    rq.req_type   = t;
    rq.level      = lv;
    rq.range_low  = lo;
    rq.range_high = hi;
    rq.probe_key  = key;
    return rq;
  endfunction

  function automatic logic signed [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // receiver: stall at random unless idle_receiver is 0, compare each accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_rsp++;
        if (rsp_pending.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result word %p", out_data_o);
        end else if (out_data_o !== rsp_pending[0]) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: expected alive=%0b ovf=%0b cnt=%0d, got alive=%0b ovf=%0b cnt=%0d",
                     rsp_pending[0].alive, rsp_pending[0].overflow, rsp_pending[0].level_count,
                     out_data_o.alive, out_data_o.overflow, out_data_o.level_count);
          void'(rsp_pending.pop_front());
        end else begin
          void'(rsp_pending.pop_front());
        end
      end
      out_stall_i <= idle_receiver ? ($urandom_range(0, 3) == 0 ||
                                      ($urandom_range(0, 60) == 0)) : 1'b0;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (rsp_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_word(mk(REQ_QUERY, 0, 0, 0, 64'sd5));
    send_word(mk(REQ_PUNCH, 0, 0, 0, 64'sd5));
    send_word(mk(REQ_INSERT, 0, 64'sd10, 64'sd10, 0));          // empty insert
    send_word(mk(REQ_INSERT, 0, 64'sd20, 64'sd10, 0));          // inverted
    send_word(mk(REQ_INSERT, 0, 64'sd10, 64'sd20, 0));
    send_word(mk(REQ_INSERT, 0, 64'sd20, 64'sd30, 0));          // touching merge
    send_word(mk(REQ_INSERT, 0, 64'sd40, 64'sd50, 0));
    send_word(mk(REQ_INSERT, 0, 64'sd5, 64'sd45, 0));           // spanning merge
    send_word(mk(REQ_QUERY, 0, 0, 0, 64'sd49));
    send_word(mk(REQ_QUERY, 0, 0, 0, 64'sd50));
    send_word(mk(REQ_PUNCH, 0, 0, 0, 64'sd5));                  // trim start
    send_word(mk(REQ_PUNCH, 0, 0, 0, 64'sd49));                 // trim end
    send_word(mk(REQ_PUNCH, 0, 0, 0, 64'sd20));                 // split
    send_word(mk(REQ_PUNCH, 0, 0, 0, 64'sd20));                 // live key
    send_word(mk(REQ_INSERT, 1, 64'sd7, 64'sd8, 0));
    send_word(mk(REQ_PUNCH, 1, 0, 0, 64'sd7));                  // drop single
    send_word(mk(REQ_INSERT, 7, {1'b1, 63'd0}, {1'b0, {63{1'b1}}}, 0));
    send_word(mk(REQ_QUERY, 7, 0, 0, {1'b1, 63'd0}));
    send_word(mk(REQ_QUERY, 7, 0, 0, {1'b0, {63{1'b1}}}));
    send_word(mk(REQ_PUNCH, 7, 0, 0, {1'b0, {63{1'b1}}} - 64'sd1));
    send_word(mk(REQ_PUNCH, 7, 0, 0, {1'b1, 63'd0}));
    send_word(mk(REQ_UNUSED, 7, rand64(), rand64(), rand64()));
    send_word(mk(REQ_UNUSED, 0, '1, '1, '1));
  endtask

  // fill a level to capacity, then force insert and split refusals
  task automatic test_full_level();
    for (int k = 0; k < MAXR; k++)
      send_word(mk(REQ_INSERT, 3, 64'(k * 4), 64'(k * 4 + 3), 0));
    send_word(mk(REQ_INSERT, 3, 64'sd1000, 64'sd1001, 0));
    send_word(mk(REQ_PUNCH, 3, 0, 0, 64'sd1));
    send_word(mk(REQ_PUNCH, 3, 0, 0, 64'sd0));
    send_word(mk(REQ_INSERT, 3, 64'sd3, 64'sd4, 0));
    send_word(mk(REQ_QUERY, 3, 0, 0, 64'sd3));
    wait_drained();
  endtask

  task automatic test_random(int n);
    lrdf_req_t rq;
    int        base;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        rq = mk(2'($urandom), 3'($urandom), rand64(), rand64(), rand64());
      end else begin
        // clustered keys so ranges overlap, touch and fill levels
        base = $urandom_range(0, 3) == 0 ? 0 : 1000;
        rq.req_type   = 2'($urandom_range(0, 2));
        rq.level      = 3'($urandom_range(0, 7));
        rq.range_low  = 64'(signed'($urandom_range(0, 600))) - 64'(base);
        rq.range_high = rq.range_low + 64'(signed'($urandom_range(0, 12)));
        rq.probe_key  = 64'(signed'($urandom_range(0, 620))) - 64'(base);
      end
      send_word(rq);
      if (k == n / 2) wait_drained();   // sender holds off until all results are back
    end
  endtask

  task automatic test_no_idle(int n);
    idle_sender   = 0;
    idle_receiver = 0;
    test_random(n);
    idle_sender   = 1;
    idle_receiver = 1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    n_err = 0; n_words = 0; n_rsp = 0; n_ovf = 0; n_dead = 0;
    for (int l = 0; l < NLEV; l++) cnt_tab[l] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_level();
    test_random(1000);
    test_no_idle(200);
    wait_drained();
    repeat (400) @(posedge clk_i);
    $display("covered %0d request words, %0d results, %0d refusals, %0d queries hitting a range",
             n_words, n_rsp, n_ovf, n_dead);
    if (n_err == 0 && rsp_pending.size() == 0) begin
      $display("tb_leveled_range_delete_filter passed");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, rsp_pending.size());
      $display("tb_leveled_range_delete_filter failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("tb_leveled_range_delete_filter failed");
    $finish;
  end

endmodule
